### hdl/drt_pkg.sv
package drt_pkg;

  // Default table depth and the cap on results reported for one operation.
  localparam int MaxRanges = 16;
  localparam int MaxOut    = 16;
  localparam int ValW      = 64;
  localparam int EmitW     = $clog2(MaxOut + 1);

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_INSERT = 2'd1,
    OP_CHOP   = 2'd2,
    OP_SPLIT  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_OVERLAP = 3'd1,
    ST_FULL    = 3'd2,
    ST_NONE    = 3'd3,
    ST_INVALID = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    K_SUMMARY     = 3'd0,
    K_OVERLAP     = 3'd1,
    K_START_TRUNC = 3'd2,
    K_SPLIT       = 3'd3,
    K_REMOVED     = 3'd4,
    K_END_TRUNC   = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE      = 3'd0,
    S_CHECK     = 3'd1,
    S_DECIDE    = 3'd2,
    S_WORK      = 3'd3,
    S_SHIFT_IN  = 3'd4,
    S_SHIFT_OUT = 3'd5,
    S_SUMMARY   = 3'd6
  } state_e;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CMD_HOLD = 2'd0,
    CMD_ROT  = 2'd1,
    CMD_INS  = 2'd2,
    CMD_DEL  = 2'd3
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e       cmd;
    logic [ValW-1:0] new_lo;
    logic [ValW-1:0] new_hi;
  } cell_ctrl_t;

endpackage

### hdl/drt_cell.sv
module drt_cell #(
  parameter int MAX_RANGES = drt_pkg::MaxRanges,
  parameter int IDX        = 0
) (
  input  logic                        clk_i,
  input  drt_pkg::cell_ctrl_t         ctrl_i,
  input  logic [$clog2(MAX_RANGES)-1:0] pos_i,
  input  logic [drt_pkg::ValW-1:0]    left_lo_i,
  input  logic [drt_pkg::ValW-1:0]    left_hi_i,
  input  logic [drt_pkg::ValW-1:0]    right_lo_i,
  input  logic [drt_pkg::ValW-1:0]    right_hi_i,
  output logic [drt_pkg::ValW-1:0]    lo_o,
  output logic [drt_pkg::ValW-1:0]    hi_o
);

  localparam int IW = $clog2(MAX_RANGES);
  localparam logic [IW-1:0] MyIdx = IW'(IDX);

  logic [drt_pkg::ValW-1:0] lo_q, lo_d;
  logic [drt_pkg::ValW-1:0] hi_q, hi_d;

  // Rotate toward the head, open a slot at pos, or close the slot at pos.
  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    case (ctrl_i.cmd)
      drt_pkg::CMD_ROT: begin
        lo_d = right_lo_i;
        hi_d = right_hi_i;
      end
      drt_pkg::CMD_INS: begin
        if (pos_i == MyIdx) begin
          lo_d = ctrl_i.new_lo;
          hi_d = ctrl_i.new_hi;
        end else if (pos_i < MyIdx) begin
          lo_d = left_lo_i;
          hi_d = left_hi_i;
        end
      end
      drt_pkg::CMD_DEL: begin
        if (pos_i <= MyIdx) begin
          lo_d = right_lo_i;
          hi_d = right_hi_i;
        end
      end
      default: begin
        lo_d = lo_q;
        hi_d = hi_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
  end

  assign lo_o = lo_q;
  assign hi_o = hi_q;

endmodule

### hdl/drt_ctrl.sv
module drt_ctrl #(
  parameter int MAX_RANGES = drt_pkg::MaxRanges
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request side
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  drt_pkg::op_e                  op_i,
  input  logic [drt_pkg::ValW-1:0]      qs_i,
  input  logic [drt_pkg::ValW-1:0]      qe_i,
  input  logic [drt_pkg::ValW-1:0]      cp_i,
  // Result side
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output drt_pkg::status_e              out_status_o,
  output drt_pkg::kind_e                out_kind_o,
  output logic [drt_pkg::ValW-1:0]      out_lo_o,
  output logic [drt_pkg::ValW-1:0]      out_hi_o,
  output logic                          out_last_o,
  // Chain
  input  logic [drt_pkg::ValW-1:0]      head_lo_i,
  input  logic [drt_pkg::ValW-1:0]      head_hi_i,
  output drt_pkg::cell_ctrl_t           cell_ctrl_o,
  output logic [$clog2(MAX_RANGES)-1:0] pos_o,
  output logic [drt_pkg::ValW-1:0]      tail_lo_o,
  output logic [drt_pkg::ValW-1:0]      tail_hi_o
);

  localparam int IW   = $clog2(MAX_RANGES);
  localparam int CNTW = $clog2(MAX_RANGES + 1);
  localparam int TW   = $clog2(MAX_RANGES + 2);
  localparam int EW   = drt_pkg::EmitW;
  localparam int LW   = ((TW > EW) ? TW : EW) + 1;
  localparam logic [IW-1:0]   LastIdx = IW'(MAX_RANGES - 1);
  localparam logic [CNTW-1:0] FullCnt = CNTW'(MAX_RANGES);
  localparam int VW = drt_pkg::ValW;

  drt_pkg::state_e  state_q, state_d;
  drt_pkg::op_e     op_q, op_d;
  logic [VW-1:0]    qs_q, qs_d, qe_q, qe_d, cp_q, cp_d;
  logic [CNTW-1:0]  count_q, count_d;
  logic [IW-1:0]    t_q, t_d;
  logic             second_q, second_d;
  logic [EW-1:0]    emit_cnt_q, emit_cnt_d;
  logic [TW-1:0]    total_q, total_d;
  logic [CNTW-1:0]  n_ov_q, n_ov_d;
  logic [CNTW-1:0]  lt_cnt_q, lt_cnt_d;
  logic             cont_q, cont_d;
  logic [IW-1:0]    cont_idx_q, cont_idx_d;
  logic [VW-1:0]    cont_hi_q, cont_hi_d;
  logic [IW-1:0]    r0_q, r0_d;
  logic [CNTW-1:0]  k_q, k_d;
  logic [IW-1:0]    pos_q, pos_d;
  logic [VW-1:0]    new_lo_q, new_lo_d, new_hi_q, new_hi_d;
  drt_pkg::status_e sum_st_q, sum_st_d;

  logic             out_valid_q, out_valid_d;
  drt_pkg::status_e out_status_q, out_status_d;
  drt_pkg::kind_e   out_kind_q, out_kind_d;
  logic [VW-1:0]    out_lo_q, out_lo_d, out_hi_q, out_hi_d;
  logic             out_last_q, out_last_d;

  // Head entry classification against the current query.
  logic hv, ov, lt, cont_chop, cont_split;
  logic free, emit_now, two, show, blocked, step, is_last;
  drt_pkg::kind_e em_kind;
  logic [VW-1:0]  em_lo, em_hi;

  assign hv         = CNTW'(t_q) < count_q;
  assign ov         = (head_hi_i > qs_q) && (head_lo_i < qe_q);
  assign lt         = head_lo_i < qs_q;
  assign cont_chop  = lt && (head_hi_i > qe_q);
  assign cont_split = (head_lo_i < cp_q) && (cp_q < head_hi_i);
  assign free       = !out_valid_q || out_ready_i;
  assign is_last    = ((LW'(emit_cnt_q) + LW'(1)) == LW'(total_q)) ||
                      (emit_cnt_q == EW'(drt_pkg::MaxOut - 1));

  // Result of the head entry during the reporting pass.
  always_comb begin
    emit_now = 1'b0;
    two      = 1'b0;
    em_kind  = drt_pkg::K_OVERLAP;
    em_lo    = head_lo_i;
    em_hi    = head_hi_i;
    case (op_q)
      drt_pkg::OP_FIND: begin
        emit_now = hv && ov;
      end
      drt_pkg::OP_CHOP: begin
        emit_now = hv && ov;
        two      = cont_chop;
        if (cont_chop && second_q) begin
          em_kind = drt_pkg::K_SPLIT;
          em_lo   = qe_q;
        end else if (lt) begin
          em_kind = drt_pkg::K_START_TRUNC;
          em_hi   = qs_q;
        end else if (head_hi_i <= qe_q) begin
          em_kind = drt_pkg::K_REMOVED;
        end else begin
          em_kind = drt_pkg::K_END_TRUNC;
          em_lo   = qe_q;
        end
      end
      drt_pkg::OP_SPLIT: begin
        emit_now = hv && (t_q == cont_idx_q);
        two      = 1'b1;
        em_kind  = drt_pkg::K_SPLIT;
        if (second_q) begin
          em_lo = cp_q;
        end else begin
          em_hi = cp_q;
        end
      end
      default: begin
        emit_now = 1'b0;
      end
    endcase
    two = two && emit_now;
  end

  assign show    = emit_now && (emit_cnt_q < EW'(drt_pkg::MaxOut));
  assign blocked = show && !free;
  assign step    = !blocked && (!two || second_q);

  // Value written back into the tail cell while the ring rotates.
  always_comb begin
    tail_lo_o = head_lo_i;
    tail_hi_o = head_hi_i;
    if (state_q == drt_pkg::S_WORK && hv) begin
      if (op_q == drt_pkg::OP_CHOP && ov) begin
        if (lt) begin
          tail_hi_o = qs_q;
        end else if (head_hi_i > qe_q) begin
          tail_lo_o = qe_q;
        end
      end else if (op_q == drt_pkg::OP_SPLIT && t_q == cont_idx_q) begin
        tail_hi_o = cp_q;
      end
    end
  end

  // Next state, counters and output register.
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    qs_d         = qs_q;
    qe_d         = qe_q;
    cp_d         = cp_q;
    count_d      = count_q;
    t_d          = t_q;
    second_d     = second_q;
    emit_cnt_d   = emit_cnt_q;
    total_d      = total_q;
    n_ov_d       = n_ov_q;
    lt_cnt_d     = lt_cnt_q;
    cont_d       = cont_q;
    cont_idx_d   = cont_idx_q;
    cont_hi_d    = cont_hi_q;
    r0_d         = r0_q;
    k_d          = k_q;
    pos_d        = pos_q;
    new_lo_d     = new_lo_q;
    new_hi_d     = new_hi_q;
    sum_st_d     = sum_st_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_kind_d   = out_kind_q;
    out_lo_d     = out_lo_q;
    out_hi_d     = out_hi_q;
    out_last_d   = out_last_q;
    cell_ctrl_o  = '{cmd: drt_pkg::CMD_HOLD, new_lo: new_lo_q, new_hi: new_hi_q};
    pos_o        = pos_q;
    in_ready_o   = 1'b0;

    case (state_q)
      drt_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d       = op_i;
          qs_d       = qs_i;
          qe_d       = qe_i;
          cp_d       = cp_i;
          t_d        = '0;
          second_d   = 1'b0;
          emit_cnt_d = '0;
          n_ov_d     = '0;
          lt_cnt_d   = '0;
          cont_d     = 1'b0;
          k_d        = '0;
          if (op_i != drt_pkg::OP_SPLIT && qe_i <= qs_i) begin
            sum_st_d = drt_pkg::ST_INVALID;
            state_d  = drt_pkg::S_SUMMARY;
          end else begin
            state_d = drt_pkg::S_CHECK;
          end
        end
      end

      // First pass: count overlaps, find the insert slot and removed block.
      drt_pkg::S_CHECK: begin
        cell_ctrl_o.cmd = drt_pkg::CMD_ROT;
        if (hv) begin
          if (ov) begin
            n_ov_d = n_ov_q + 1'b1;
          end
          if (lt) begin
            lt_cnt_d = lt_cnt_q + 1'b1;
          end
          if ((op_q == drt_pkg::OP_CHOP && cont_chop) ||
              (op_q == drt_pkg::OP_SPLIT && cont_split)) begin
            cont_d     = 1'b1;
            cont_idx_d = t_q;
            cont_hi_d  = head_hi_i;
          end
          if (ov && !lt && head_hi_i <= qe_q) begin
            if (k_q == '0) begin
              r0_d = t_q;
            end
            k_d = k_q + 1'b1;
          end
        end
        if (t_q == LastIdx) begin
          t_d     = '0;
          state_d = drt_pkg::S_DECIDE;
        end else begin
          t_d = t_q + 1'b1;
        end
      end

      drt_pkg::S_DECIDE: begin
        pos_d    = IW'(cont_idx_q + 1'b1);
        new_hi_d = cont_hi_q;
        case (op_q)
          drt_pkg::OP_FIND: begin
            total_d = TW'(n_ov_q);
            if (n_ov_q == '0) begin
              sum_st_d = drt_pkg::ST_NONE;
              state_d  = drt_pkg::S_SUMMARY;
            end else begin
              state_d = drt_pkg::S_WORK;
            end
          end
          drt_pkg::OP_INSERT: begin
            pos_d    = lt_cnt_q[IW-1:0];
            new_lo_d = qs_q;
            new_hi_d = qe_q;
            state_d  = drt_pkg::S_SUMMARY;
            if (n_ov_q != '0) begin
              sum_st_d = drt_pkg::ST_OVERLAP;
            end else if (count_q == FullCnt) begin
              sum_st_d = drt_pkg::ST_FULL;
            end else begin
              sum_st_d = drt_pkg::ST_OK;
              state_d  = drt_pkg::S_SHIFT_IN;
            end
          end
          drt_pkg::OP_CHOP: begin
            new_lo_d = qe_q;
            total_d  = TW'(n_ov_q) + TW'(cont_q);
            if (n_ov_q == '0) begin
              sum_st_d = drt_pkg::ST_NONE;
              state_d  = drt_pkg::S_SUMMARY;
            end else if (cont_q && count_q == FullCnt) begin
              sum_st_d = drt_pkg::ST_FULL;
              state_d  = drt_pkg::S_SUMMARY;
            end else begin
              state_d = drt_pkg::S_WORK;
            end
          end
          default: begin
            new_lo_d = cp_q;
            total_d  = TW'(2);
            if (!cont_q) begin
              sum_st_d = drt_pkg::ST_NONE;
              state_d  = drt_pkg::S_SUMMARY;
            end else if (count_q == FullCnt) begin
              sum_st_d = drt_pkg::ST_FULL;
              state_d  = drt_pkg::S_SUMMARY;
            end else begin
              state_d = drt_pkg::S_WORK;
            end
          end
        endcase
      end

      // Second pass: report and trim entries as they pass the head.
      drt_pkg::S_WORK: begin
        if (show && free) begin
          out_valid_d  = 1'b1;
          out_status_d = drt_pkg::ST_OK;
          out_kind_d   = em_kind;
          out_lo_d     = em_lo;
          out_hi_d     = em_hi;
          out_last_d   = is_last;
          emit_cnt_d   = emit_cnt_q + 1'b1;
        end
        if (two && !blocked) begin
          second_d = !second_q;
        end
        if (step) begin
          cell_ctrl_o.cmd = drt_pkg::CMD_ROT;
          if (t_q == LastIdx) begin
            t_d = '0;
            if (op_q == drt_pkg::OP_SPLIT || (op_q == drt_pkg::OP_CHOP && cont_q)) begin
              state_d = drt_pkg::S_SHIFT_IN;
            end else if (op_q == drt_pkg::OP_CHOP && k_q != '0) begin
              state_d = drt_pkg::S_SHIFT_OUT;
            end else begin
              state_d = drt_pkg::S_IDLE;
            end
          end else begin
            t_d = t_q + 1'b1;
          end
        end
      end

      drt_pkg::S_SHIFT_IN: begin
        cell_ctrl_o.cmd = drt_pkg::CMD_INS;
        count_d         = count_q + 1'b1;
        state_d         = (op_q == drt_pkg::OP_INSERT) ? drt_pkg::S_SUMMARY : drt_pkg::S_IDLE;
      end

      // One removed entry closes up per cycle.
      drt_pkg::S_SHIFT_OUT: begin
        cell_ctrl_o.cmd = drt_pkg::CMD_DEL;
        pos_o           = r0_q;
        count_d         = count_q - 1'b1;
        k_d             = k_q - 1'b1;
        if (k_q == CNTW'(1)) begin
          state_d = drt_pkg::S_IDLE;
        end
      end

      drt_pkg::S_SUMMARY: begin
        if (free) begin
          out_valid_d  = 1'b1;
          out_status_d = sum_st_q;
          out_kind_d   = drt_pkg::K_SUMMARY;
          out_lo_d     = (sum_st_q == drt_pkg::ST_OK) ? qs_q : '0;
          out_hi_d     = (sum_st_q == drt_pkg::ST_OK) ? qe_q : '0;
          out_last_d   = 1'b1;
          state_d      = drt_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = drt_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= drt_pkg::S_IDLE;
      count_q     <= '0;
      t_q         <= '0;
      second_q    <= 1'b0;
      emit_cnt_q  <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      t_q         <= t_d;
      second_q    <= second_d;
      emit_cnt_q  <= emit_cnt_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Operands and bookkeeping of the current operation.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    qs_q         <= qs_d;
    qe_q         <= qe_d;
    cp_q         <= cp_d;
    total_q      <= total_d;
    n_ov_q       <= n_ov_d;
    lt_cnt_q     <= lt_cnt_d;
    cont_q       <= cont_d;
    cont_idx_q   <= cont_idx_d;
    cont_hi_q    <= cont_hi_d;
    r0_q         <= r0_d;
    pos_q        <= pos_d;
    new_lo_q     <= new_lo_d;
    new_hi_q     <= new_hi_d;
    sum_st_q     <= sum_st_d;
    out_status_q <= out_status_d;
    out_kind_q   <= out_kind_d;
    out_lo_q     <= out_lo_d;
    out_hi_q     <= out_hi_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_kind_o   = out_kind_q;
  assign out_lo_o     = out_lo_q;
  assign out_hi_o     = out_hi_q;
  assign out_last_o   = out_last_q;

  // The table never holds more ranges than it has cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FullCnt)
    else $error("range count exceeds table depth");

  // No operation reports more results than the cap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_cnt_q <= EW'(drt_pkg::MaxOut))
    else $error("result cap exceeded");

  // An insertion into the chain only happens when a free cell exists.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == drt_pkg::S_SHIFT_IN) |-> (count_q < FullCnt))
    else $error("insertion into a full table");

  // An accepted request always starts work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != drt_pkg::S_IDLE))
    else $error("accepted request was dropped");

endmodule

### hdl/disjoint_range_table_top.sv
// Sorted table of up to MAX_RANGES disjoint half-open ranges [start, end).
// Requests arrive on the s_axis channel: tuser carries the operation (find,
// insert, chop, split), tdata the query bounds and the cut point. Results
// leave on the m_axis channel, one transfer per reported range or one
// summary transfer, with tlast on the final transfer of each request.
// The ranges live in a chain of cells that rotates toward the head. Every
// request but a find, insert or chop on an empty or inverted range first
// rotates the chain once to classify all entries and takes a decision
// step. Unless rejected, find, chop and split then rotate once more while
// results are reported and entries trimmed; a range reported as two pieces
// holds the chain until both are sent. A chop that removed ranges then
// closes them up in turn; split or a chop that splits a range inserts the
// upper piece. An accepted insert opens its slot, then reports a summary;
// a request rejected after the scan, or a find, insert or chop on an empty
// or inverted range, reports only the summary. One request is in work at a
// time; s_axis_tready_o is high while the block is idle. A single output
// register holds the next result; when the receiver stalls, the chain
// stops at the next range to report until the transfer completes.
// Reset empties the table and drops any pending result.
module disjoint_range_table_top #(
  parameter int MAX_RANGES = drt_pkg::MaxRanges
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // Bits from 0: query_start[63:0], query_end[127:64], cut_point[191:128].
  input  logic [191:0] s_axis_tdata_i,
  // Bits from 0: op[1:0].
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // Bits from 0: status[2:0], item_start[66:3], item_end[130:67], zero fill.
  output logic [135:0] m_axis_tdata_o,
  // Bits from 0: kind[2:0].
  output logic [2:0]   m_axis_tuser_o,
  output logic         m_axis_tlast_o
);

  localparam int IW = $clog2(MAX_RANGES);
  localparam int VW = drt_pkg::ValW;

  drt_pkg::cell_ctrl_t cell_ctrl;
  logic [IW-1:0]       pos;
  logic [VW-1:0]       tail_lo, tail_hi;
  logic [VW-1:0]       lo_w [MAX_RANGES];
  logic [VW-1:0]       hi_w [MAX_RANGES];
  drt_pkg::status_e    out_status;
  drt_pkg::kind_e      out_kind;
  logic [VW-1:0]       out_lo, out_hi;

  drt_ctrl #(
    .MAX_RANGES(MAX_RANGES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .op_i        (drt_pkg::op_e'(s_axis_tuser_i)),
    .qs_i        (s_axis_tdata_i[63:0]),
    .qe_i        (s_axis_tdata_i[127:64]),
    .cp_i        (s_axis_tdata_i[191:128]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_status_o(out_status),
    .out_kind_o  (out_kind),
    .out_lo_o    (out_lo),
    .out_hi_o    (out_hi),
    .out_last_o  (m_axis_tlast_o),
    .head_lo_i   (lo_w[0]),
    .head_hi_i   (hi_w[0]),
    .cell_ctrl_o (cell_ctrl),
    .pos_o       (pos),
    .tail_lo_o   (tail_lo),
    .tail_hi_o   (tail_hi)
  );

  // Chain of cells; the tail cell takes the value fed back by the controller.
  for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
    logic [VW-1:0] left_lo, left_hi, right_lo, right_hi;
    if (i == 0) begin : g_first
      assign left_lo = tail_lo;
      assign left_hi = tail_hi;
    end else begin : g_mid
      assign left_lo = lo_w[i-1];
      assign left_hi = hi_w[i-1];
    end
    if (i == MAX_RANGES - 1) begin : g_last
      assign right_lo = tail_lo;
      assign right_hi = tail_hi;
    end else begin : g_inner
      assign right_lo = lo_w[i+1];
      assign right_hi = hi_w[i+1];
    end
    drt_cell #(
      .MAX_RANGES(MAX_RANGES),
      .IDX       (i)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (cell_ctrl),
      .pos_i     (pos),
      .left_lo_i (left_lo),
      .left_hi_i (left_hi),
      .right_lo_i(right_lo),
      .right_hi_i(right_hi),
      .lo_o      (lo_w[i]),
      .hi_o      (hi_w[i])
    );
  end

  assign m_axis_tdata_o = {5'b0, out_hi, out_lo, out_status};
  assign m_axis_tuser_o = out_kind;

endmodule
